FILE: sv/dhft_pkg.sv
// shared types, constants and hash functions for the flow filter table
`default_nettype none
package dhft_pkg;
   localparam int ENTRIES = 1024;
   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = IDX_W + 1;
   localparam int KEY_W = 104;
   localparam int QDEPTH = 2;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_LOOKUP = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_EMPTY = 2'd0,
      KIND_USED = 2'd1,
      KIND_TOMB = 2'd2,
      KIND_RSVD = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_NOTFOUND = 3'd1,
      ST_DUP = 3'd2,
      ST_FULL = 3'd3,
      ST_BADHANDLE = 3'd4
   } status_type;

   typedef struct packed {
      logic [31:0] local_addr;
      logic [15:0] local_port;
      logic [31:0] remote_addr;
      logic [15:0] remote_port;
      logic [7:0] protocol;
   } key_type;

   typedef struct packed {
      mode_type mode;
      key_type key;
      logic [15:0] owner;
      logic [IDX_W-1:0] hidx;
      logic bad_hidx;
   } cmd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD,
      S_EVAL,
      S_INS_WALK_RD,
      S_INS_WALK,
      S_RM_KEY_RD,
      S_RM_KEY,
      S_RM_WALK_RD,
      S_RM_WALK,
      S_DONE
   } state_type;

   function automatic logic [31:0] key_mix(input key_type k);
      key_mix = k.local_addr ^ {16'd0, k.local_port} ^ k.remote_addr
         ^ {16'd0, k.remote_port} ^ {24'd0, k.protocol};
   endfunction

   function automatic logic [IDX_W-1:0] start_of(input logic [31:0] m);
      logic [31:0] h;
      h = m ^ (m >> 16);
      h = h ^ (h >> 8);
      start_of = h[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] step_of(input logic [31:0] m);
      step_of = m[IDX_W-1:0] | {{(IDX_W-1){1'b0}}, 1'b1};
   endfunction
endpackage
`default_nettype wire

FILE: sv/dhft_front.sv
// front end: accepts commands, checks handles and queues them for the engine
`default_nettype none
module dhft_front (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic [1:0] req_mode,
   input wire logic [31:0] req_local_addr,
   input wire logic [15:0] req_local_port,
   input wire logic [31:0] req_remote_addr,
   input wire logic [15:0] req_remote_port,
   input wire logic [7:0] req_protocol,
   input wire logic [15:0] req_owner_in,
   input wire logic [9:0] req_handle_in,
   input wire logic eng_idle,
   input wire logic pop,
   output logic q_valid,
   output dhft_pkg::cmd_type q_cmd
);
   localparam int PW = $clog2(dhft_pkg::QDEPTH);
   dhft_pkg::cmd_type mem_ff [dhft_pkg::QDEPTH];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0] cnt_ff, cnt_in;
   logic [PW:0] pend_ff, pend_in;
   logic push;
   dhft_pkg::cmd_type cmd;

   // one transaction in flight at a time: queue plus engine
   assign busy = (pend_ff != '0) || !eng_idle;
   assign push = start && !busy;

   // classify the incoming transaction
   always_comb begin
      cmd.mode = dhft_pkg::mode_type'(req_mode);
      cmd.key.local_addr = req_local_addr;
      cmd.key.local_port = req_local_port;
      cmd.key.remote_addr = req_remote_addr;
      cmd.key.remote_port = req_remote_port;
      cmd.key.protocol = req_protocol;
      cmd.owner = req_owner_in;
      cmd.hidx = req_handle_in[dhft_pkg::IDX_W-1:0];
      cmd.bad_hidx = (32'(req_handle_in) >= 32'(dhft_pkg::ENTRIES));
   end

   // queue pointers
   always_comb begin
      wp_in = push ? wp_ff + 1'b1 : wp_ff;
      rp_in = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
      pend_in = cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
         pend_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
         pend_ff <= pend_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= cmd;
      end
   end

   assign q_valid = (cnt_ff != '0);
   assign q_cmd = mem_ff[rp_ff];
endmodule
`default_nettype wire

FILE: sv/dhft_engine.sv
// back end: probe sequencer over the slot memories
`default_nettype none
module dhft_engine (
   input wire logic clock,
   input wire logic reset,
   input wire logic q_valid,
   input dhft_pkg::cmd_type q_cmd,
   output logic pop,
   output logic eng_idle,
   output logic rsp_valid,
   output logic [2:0] rsp_status,
   output logic [9:0] rsp_handle,
   output logic [15:0] rsp_owner_out
);
   localparam int IW = dhft_pkg::IDX_W;
   localparam int CW = dhft_pkg::CNT_W;
   localparam int N = dhft_pkg::ENTRIES;

   // slot memories: kind and count cleared by a sweep after reset
   logic [1:0] kind_mem [N];
   logic [CW-1:0] cnt_mem [N];
   logic [dhft_pkg::KEY_W-1:0] key_mem [N];
   logic [15:0] own_mem [N];

   dhft_pkg::state_type st_ff, st_in;
   dhft_pkg::cmd_type cmd_ff;
   dhft_pkg::key_type skey_ff, skey_in;
   logic [IW-1:0] first_ff, first_in, cur_ff, cur_in, step_ff, step_in;
   logic [IW-1:0] tgt_ff, tgt_in;
   logic [IW:0] n_ff, n_in;
   logic wild_ff, wild_in;
   logic [IW:0] clr_ff;
   logic clearing;
   logic [2:0] sts_ff, sts_in;
   logic [IW-1:0] hdl_ff, hdl_in;
   logic [15:0] own_ff, own_in;

   logic [1:0] rd_kind;
   logic [CW-1:0] rd_cnt;
   dhft_pkg::key_type rd_key;
   logic [15:0] rd_own;
   logic [IW-1:0] rd_addr;
   logic wr_en, wr_key;
   logic [IW-1:0] wr_addr;
   logic [1:0] wr_kind;
   logic [CW-1:0] wr_cnt;
   logic match, wildkey;
   logic [IW-1:0] nxt;
   logic [CW-1:0] dec;

   assign clearing = !clr_ff[IW];
   assign eng_idle = (st_ff == dhft_pkg::S_IDLE) && !clearing;
   assign pop = eng_idle && q_valid;
   assign nxt = cur_ff + step_ff;
   assign dec = (rd_cnt != '0) ? rd_cnt - 1'b1 : rd_cnt;
   assign wildkey = (skey_ff.remote_addr == '0) && (skey_ff.remote_port == '0);

   // key compare against the slot read
   always_comb begin
      match = (rd_kind == dhft_pkg::KIND_USED)
         && rd_key.local_addr == skey_ff.local_addr
         && rd_key.local_port == skey_ff.local_port
         && rd_key.protocol == skey_ff.protocol
         && (wildkey || (rd_key.remote_addr == skey_ff.remote_addr
            && rd_key.remote_port == skey_ff.remote_port));
   end

   // reset sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (clearing) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         dhft_pkg::S_IDLE: if (pop) begin
            priority if (q_cmd.mode == dhft_pkg::MODE_REMOVE) begin
               st_in = q_cmd.bad_hidx ? dhft_pkg::S_DONE : dhft_pkg::S_RM_KEY_RD;
            end else if (q_cmd.mode == dhft_pkg::MODE_NONE) begin
               st_in = dhft_pkg::S_DONE;
            end else begin
               st_in = dhft_pkg::S_RD;
            end
         end
         dhft_pkg::S_RD: st_in = dhft_pkg::S_EVAL;
         dhft_pkg::S_EVAL: begin
            if (cmd_ff.mode == dhft_pkg::MODE_INSERT) begin
               priority if (rd_kind != dhft_pkg::KIND_USED) st_in = dhft_pkg::S_INS_WALK_RD;
               else if (match || nxt == first_ff) st_in = dhft_pkg::S_DONE;
               else st_in = dhft_pkg::S_EVAL;
            end else begin
               priority if (match) st_in = dhft_pkg::S_DONE;
               else if (rd_kind == dhft_pkg::KIND_EMPTY || nxt == first_ff)
                  st_in = (wild_ff || wildkey) ? dhft_pkg::S_DONE : dhft_pkg::S_RD;
               else st_in = dhft_pkg::S_EVAL;
            end
         end
         dhft_pkg::S_INS_WALK_RD: st_in = dhft_pkg::S_INS_WALK;
         dhft_pkg::S_INS_WALK:
            st_in = (cur_ff == tgt_ff) ? dhft_pkg::S_DONE : dhft_pkg::S_INS_WALK_RD;
         dhft_pkg::S_RM_KEY_RD: st_in = dhft_pkg::S_RM_KEY;
         dhft_pkg::S_RM_KEY:
            st_in = (rd_kind == dhft_pkg::KIND_USED) ? dhft_pkg::S_RM_WALK_RD
               : dhft_pkg::S_DONE;
         dhft_pkg::S_RM_WALK_RD: st_in = dhft_pkg::S_RM_WALK;
         dhft_pkg::S_RM_WALK:
            st_in = (cur_ff == tgt_ff || n_ff[IW]) ? dhft_pkg::S_DONE
               : dhft_pkg::S_RM_WALK_RD;
         dhft_pkg::S_DONE: st_in = dhft_pkg::S_IDLE;
         default: st_in = dhft_pkg::S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      skey_in = skey_ff;
      first_in = first_ff;
      cur_in = cur_ff;
      step_in = step_ff;
      tgt_in = tgt_ff;
      n_in = n_ff;
      wild_in = wild_ff;
      sts_in = sts_ff;
      hdl_in = hdl_ff;
      own_in = own_ff;
      rd_addr = cur_ff;
      wr_en = 1'b0;
      wr_key = 1'b0;
      wr_addr = cur_ff;
      wr_kind = rd_kind;
      wr_cnt = rd_cnt;
      unique case (st_ff)
         dhft_pkg::S_IDLE: begin
            skey_in = q_cmd.key;
            wild_in = 1'b0;
            hdl_in = '0;
            own_in = '0;
            first_in = dhft_pkg::start_of(dhft_pkg::key_mix(q_cmd.key));
            step_in = dhft_pkg::step_of(dhft_pkg::key_mix(q_cmd.key));
            cur_in = q_cmd.hidx;
            tgt_in = q_cmd.hidx;
            unique case (q_cmd.mode)
               dhft_pkg::MODE_INSERT: sts_in = dhft_pkg::ST_FULL;
               dhft_pkg::MODE_REMOVE: begin
                  sts_in = dhft_pkg::ST_BADHANDLE;
                  hdl_in = q_cmd.hidx;
               end
               default: sts_in = dhft_pkg::ST_NOTFOUND;
            endcase
         end
         dhft_pkg::S_RD: begin
            if (wild_ff) begin
               skey_in.remote_addr = '0;
               skey_in.remote_port = '0;
            end
            first_in = dhft_pkg::start_of(dhft_pkg::key_mix(skey_in));
            step_in = dhft_pkg::step_of(dhft_pkg::key_mix(skey_in));
            cur_in = first_in;
            rd_addr = first_in;
         end
         dhft_pkg::S_EVAL: begin
            rd_addr = nxt;
            cur_in = nxt;
            if (cmd_ff.mode == dhft_pkg::MODE_INSERT) begin
               if (rd_kind != dhft_pkg::KIND_USED) begin
                  tgt_in = cur_ff;
                  cur_in = first_ff;
                  sts_in = dhft_pkg::ST_OK;
                  hdl_in = cur_ff;
               end else if (match) begin
                  sts_in = dhft_pkg::ST_DUP;
                  hdl_in = cur_ff;
                  own_in = rd_own;
               end
            end else begin
               if (match) begin
                  sts_in = dhft_pkg::ST_OK;
                  hdl_in = cur_ff;
                  own_in = rd_own;
               end else if (rd_kind == dhft_pkg::KIND_EMPTY || nxt == first_ff) begin
                  wild_in = 1'b1;
               end
            end
         end
         dhft_pkg::S_INS_WALK_RD: rd_addr = cur_ff;
         dhft_pkg::S_INS_WALK: begin
            wr_en = 1'b1;
            wr_cnt = rd_cnt + 1'b1;
            if (cur_ff == tgt_ff) begin
               wr_kind = dhft_pkg::KIND_USED;
               wr_key = 1'b1;
            end
            cur_in = nxt;
         end
         dhft_pkg::S_RM_KEY_RD: rd_addr = tgt_ff;
         dhft_pkg::S_RM_KEY: begin
            skey_in = rd_key;
            first_in = dhft_pkg::start_of(dhft_pkg::key_mix(rd_key));
            step_in = dhft_pkg::step_of(dhft_pkg::key_mix(rd_key));
            cur_in = first_in;
            n_in = '0;
            if (rd_kind == dhft_pkg::KIND_USED) sts_in = dhft_pkg::ST_OK;
         end
         dhft_pkg::S_RM_WALK_RD: rd_addr = cur_ff;
         dhft_pkg::S_RM_WALK: begin
            wr_en = 1'b1;
            wr_cnt = dec;
            n_in = n_ff + 1'b1;
            if (cur_ff == tgt_ff || n_ff[IW]) begin
               wr_addr = tgt_ff;
               wr_kind = (cur_ff == tgt_ff && dec != '0) ? dhft_pkg::KIND_TOMB
                  : dhft_pkg::KIND_EMPTY;
               if (cur_ff != tgt_ff) begin
                  wr_en = 1'b1;
               end
            end else if (rd_kind == dhft_pkg::KIND_TOMB && dec == '0) begin
               wr_kind = dhft_pkg::KIND_EMPTY;
            end
            cur_in = nxt;
         end
         default: ;
      endcase
   end

   // registered state
   always_ff @(posedge clock) begin
      if (reset) st_ff <= dhft_pkg::S_IDLE;
      else st_ff <= st_in;
   end

   always_ff @(posedge clock) begin
      if (pop) cmd_ff <= q_cmd;
      skey_ff <= skey_in;
      first_ff <= first_in;
      cur_ff <= cur_in;
      step_ff <= step_in;
      tgt_ff <= tgt_in;
      n_ff <= n_in;
      wild_ff <= wild_in;
      sts_ff <= sts_in;
      hdl_ff <= hdl_in;
      own_ff <= own_in;
   end

   // slot memories, one read and one write port each
   always_ff @(posedge clock) begin
      if (clearing) begin
         kind_mem[clr_ff[IW-1:0]] <= dhft_pkg::KIND_EMPTY;
         cnt_mem[clr_ff[IW-1:0]] <= '0;
      end else if (wr_en) begin
         kind_mem[wr_addr] <= wr_kind;
         cnt_mem[wr_addr] <= wr_cnt;
      end
      rd_kind <= kind_mem[rd_addr];
      rd_cnt <= cnt_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_key) begin
         key_mem[wr_addr] <= cmd_ff.key;
         own_mem[wr_addr] <= cmd_ff.owner;
      end
      rd_key <= key_mem[rd_addr];
      rd_own <= own_mem[rd_addr];
   end

   // response strobe
   assign rsp_valid = (st_ff == dhft_pkg::S_DONE);
   assign rsp_status = sts_ff;
   assign rsp_handle = 10'(hdl_ff);
   assign rsp_owner_out = own_ff;
endmodule
`default_nettype wire

FILE: sv/double_hash_flow_filter_table_top.sv
// top level of the double hashed flow filter table
//  channel  | ports                        | transfer
//  request  | start, busy, req_*           | start && !busy
//  response | rsp_valid, rsp_*             | one cycle strobe, no stall
// one transaction at a time: insert and lookup evaluate each probed slot; a
// missed lookup retries once with a wildcard key; insert then reads and
// writes each slot on its path; remove reads the handle's slot, then reads and
// writes each slot on the stored key's path. busy drops the cycle after the
// response strobe. after reset a sweep over all ENTRIES slots clears slot
// kinds and counts, busy is high meanwhile. the response side cannot stall.
`default_nettype none
module double_hash_flow_filter_table_top (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic [1:0] req_mode,
   input wire logic [31:0] req_local_addr,
   input wire logic [15:0] req_local_port,
   input wire logic [31:0] req_remote_addr,
   input wire logic [15:0] req_remote_port,
   input wire logic [7:0] req_protocol,
   input wire logic [15:0] req_owner_in,
   input wire logic [9:0] req_handle_in,
   output logic rsp_valid,
   output logic [2:0] rsp_status,
   output logic [9:0] rsp_handle,
   output logic [15:0] rsp_owner_out
);
   logic eng_idle, pop, q_valid;
   dhft_pkg::cmd_type q_cmd;

   // command intake and queue
   dhft_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_local_addr(req_local_addr),
      .req_local_port(req_local_port), .req_remote_addr(req_remote_addr),
      .req_remote_port(req_remote_port), .req_protocol(req_protocol),
      .req_owner_in(req_owner_in), .req_handle_in(req_handle_in),
      .eng_idle(eng_idle), .pop(pop), .q_valid(q_valid), .q_cmd(q_cmd)
   );

   // probe engine
   dhft_engine u_engine (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_cmd(q_cmd),
      .pop(pop), .eng_idle(eng_idle), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_handle(rsp_handle),
      .rsp_owner_out(rsp_owner_out)
   );
endmodule
`default_nettype wire

FILE: sv/dhft_checker.sv
// port level checks of the flow filter table
`default_nettype none
module dhft_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire logic [2:0] rsp_status,
   input wire logic [15:0] rsp_owner_out
);
   // accepted transaction raises busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised");
   // no two responses back to back
   a_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double response");
   // status in range
   a_sts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= dhft_pkg::ST_BADHANDLE) else $error("bad status");
   // failures carry no owner
   a_own: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == dhft_pkg::ST_NOTFOUND
         || rsp_status == dhft_pkg::ST_FULL || rsp_status == dhft_pkg::ST_BADHANDLE)
      |-> rsp_owner_out == '0) else $error("owner on failure");
endmodule

bind double_hash_flow_filter_table_top dhft_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_owner_out(rsp_owner_out)
);
`default_nettype wire
